>>> sv/adc_request_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ADC request sequencer assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADC_REQUEST_SEQUENCER_DEFINES_SVH
`define ADC_REQUEST_SEQUENCER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ADCRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ADCRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/adcrs_pkg.sv
// ----------------------------------------------------------------------------
// ADC request sequencer package
// Operation and result codes, phase encoding and shared structs.
// ----------------------------------------------------------------------------
package adcrs_pkg;

    // Input operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_START_REJECT = 3'd0;
    localparam logic [2:0] KIND_START_ACCEPT = 3'd1;
    localparam logic [2:0] KIND_SETUP        = 3'd2;
    localparam logic [2:0] KIND_DATA         = 3'd3;
    localparam logic [2:0] KIND_BAD_REQUEST  = 3'd4;
    localparam logic [2:0] KIND_DROPPED      = 3'd5;

    // Configuration register indexes
    localparam logic CFG_ENABLE_PINS  = 1'b0;
    localparam logic CFG_ADDRESS_PINS = 1'b1;

    localparam logic [4:0] NO_PIN  = 5'd16;
    localparam logic [5:0] NO_ADDR = 6'd32;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_REQ  = 3'b010,
        PH_SAMP = 3'b100
    } phase_t;

    // Fields of one packed request word
    typedef struct packed {
        logic [15:0] mask;
        logic [3:0]  count;
        logic [3:0]  enable;
        logic [4:0]  address;
        logic        mux_sel;
        logic        sweep;
    } req_fields_t;

    // Decoded and checked request
    typedef struct packed {
        req_fields_t f;
        logic        sum_mode;
        logic        bad;
        logic [4:0]  release_pin;
        logic [4:0]  assert_pin;
        logic [5:0]  mux_address;
    } req_dec_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  release_pin;
        logic [4:0]  assert_pin;
        logic [5:0]  mux_address;
        logic [15:0] channel_mask;
        logic [3:0]  conversion_count;
        logic        sweep_mode;
        logic [15:0] data_value;
        logic [5:0]  data_index;
        logic        batch_done;
        logic        busy_res;
    } result_t;

endpackage

>>> sv/adcrs_decode.sv
// ----------------------------------------------------------------------------
// ADC request decoder
// Unpacks a request word, checks it against the wired pins and the free
// store slots, and picks the enable pins to release and assert.
// ----------------------------------------------------------------------------
module adcrs_decode #(
    parameter int DATA_DEPTH      = 64,
    parameter int ENABLE_PINS_MAX = 16,
    parameter int SLOT_W          = 7
) (
    input  logic [31:0]          request_word,
    input  logic [4:0]           enable_pin_count,
    input  logic [2:0]           address_pin_count,
    input  logic [4:0]           previous_enable,
    input  logic [SLOT_W-1:0]    next_data_slot,
    output adcrs_pkg::req_dec_t  dec
);

    localparam int CHK_W = $clog2(DATA_DEPTH + 17);
    localparam logic [4:0] EN_MAX = 5'(ENABLE_PINS_MAX);

    adcrs_pkg::req_fields_t f;
    logic [4:0]       need;
    logic [4:0]       en_lim;
    logic             en_bad;
    logic             addr_bad;
    logic             depth_bad;
    logic [CHK_W-1:0] fill;

    assign f = adcrs_pkg::req_fields_t'({request_word[31:16], request_word[15:12],
                                         request_word[11:8], request_word[6:2],
                                         request_word[1], request_word[0]});

    always_comb
    begin
        dec          = '0;
        dec.f        = f;
        dec.sum_mode = !f.sweep && (f.count != 4'd0);

        // a summed request stores one word, any other one word per sample
        need   = dec.sum_mode ? 5'd1 : ({1'b0, f.count} + 5'd1);
        en_lim = (enable_pin_count < EN_MAX) ? enable_pin_count : EN_MAX;
        en_bad = ({1'b0, f.enable} >= en_lim);
        addr_bad  = (({3'b000, f.address} >> address_pin_count) != 8'd0);
        fill      = CHK_W'(next_data_slot) + CHK_W'(need);
        depth_bad = (fill > CHK_W'(DATA_DEPTH));

        dec.bad = (request_word == 32'd0) || (f.mux_sel && (en_bad || addr_bad)) || depth_bad;

        dec.release_pin = adcrs_pkg::NO_PIN;
        dec.assert_pin  = adcrs_pkg::NO_PIN;
        dec.mux_address = adcrs_pkg::NO_ADDR;
        if (f.mux_sel)
        begin
            dec.mux_address = {1'b0, f.address};
            // break before make: release the old pin only on a change
            if ({1'b0, f.enable} != previous_enable)
            begin
                dec.release_pin = (previous_enable < EN_MAX) ? previous_enable
                                                             : adcrs_pkg::NO_PIN;
                dec.assert_pin  = {1'b0, f.enable};
            end
        end
    end

endmodule

>>> sv/adc_request_sequencer.sv
// ----------------------------------------------------------------------------
// ADC request sequencer
// Opens request batches, decodes and checks request words, drives the mux
// pin sequence and sums or forwards ADC samples into indexed data words.
// ----------------------------------------------------------------------------
// A result, where one is produced, is registered when its request is accepted and is valid in the next cycle.
// Throughput: one request per cycle; the single result register sets it,
//   and in_ready drops only while a held result is not taken.
// A non-final sample of a summed conversion produces no result.
// Reset (rst_n low, asynchronous): idle, no batch, config registers zero,
//   no enable pin asserted, result register empty.
`include "adc_request_sequencer_defines.svh"

module adc_request_sequencer #(
    parameter int DATA_DEPTH      = 64,
    parameter int SAMPLE_BITS     = 12,
    parameter int ENABLE_PINS_MAX = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,

    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  num_reads,
    input  logic [31:0] request_word,
    input  logic [11:0] sample,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [4:0]  release_pin,
    output logic [4:0]  assert_pin,
    output logic [5:0]  mux_address,
    output logic [15:0] channel_mask,
    output logic [3:0]  conversion_count,
    output logic        sweep_mode,
    output logic [15:0] data_value,
    output logic [5:0]  data_index,
    output logic        batch_done,
    output logic        busy_res
);

    // next_data_slot must reach DATA_DEPTH itself
    localparam int SLOT_W = $clog2(DATA_DEPTH + 1);
    // sample port is 12 bits; use at most SAMPLE_BITS of them
    localparam int SMP_W  = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [4:0]          enable_pin_count_reg;
    logic [2:0]          address_pin_count_reg;

    adcrs_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]          batch_length_reg, batch_length_next;
    logic [7:0]          requests_done_reg, requests_done_next;
    logic [SLOT_W-1:0]   next_data_slot_reg, next_data_slot_next;
    logic [4:0]          samples_left_reg, samples_left_next;
    logic [15:0]         running_sum_reg, running_sum_next;
    logic                summing_mode_reg, summing_mode_next;
    logic [4:0]          previous_enable_reg, previous_enable_next;

    logic                out_valid_reg, out_valid_next;
    adcrs_pkg::result_t  result_reg, result_next;

    logic                in_fire;
    logic                emit;
    adcrs_pkg::req_dec_t dec;

    // Accept a new request whenever the result register is free or draining.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Request word decode and checks
    // ------------------------------------------------------------------
    adcrs_decode #(
        .DATA_DEPTH      (DATA_DEPTH),
        .ENABLE_PINS_MAX (ENABLE_PINS_MAX),
        .SLOT_W          (SLOT_W)
    ) u_decode (
        .request_word      (request_word),
        .enable_pin_count  (enable_pin_count_reg),
        .address_pin_count (address_pin_count_reg),
        .previous_enable   (previous_enable_reg),
        .next_data_slot    (next_data_slot_reg),
        .dec               (dec)
    );

    // ------------------------------------------------------------------
    // Next state and result
    // ------------------------------------------------------------------
    always_comb
    begin
        logic        busy;
        logic [7:0]  done_inc;
        logic        more;
        logic [4:0]  left;
        logic        last;
        logic [15:0] smp;
        logic [15:0] sum;

        busy     = (requests_done_reg < batch_length_reg);
        done_inc = requests_done_reg + 8'd1;
        more     = (done_inc < batch_length_reg);
        left     = samples_left_reg - 5'd1;
        last     = (left == 5'd0);
        smp      = 16'(sample[SMP_W-1:0]);
        sum      = running_sum_reg + smp;

        phase_next           = phase_reg;
        batch_length_next    = batch_length_reg;
        requests_done_next   = requests_done_reg;
        next_data_slot_next  = next_data_slot_reg;
        samples_left_next    = samples_left_reg;
        running_sum_next     = running_sum_reg;
        summing_mode_next    = summing_mode_reg;
        previous_enable_next = previous_enable_reg;

        // idle fields hold fixed values; busy reflects state after the request
        result_next             = '0;
        result_next.kind        = adcrs_pkg::KIND_DROPPED;
        result_next.release_pin = adcrs_pkg::NO_PIN;
        result_next.assert_pin  = adcrs_pkg::NO_PIN;
        result_next.mux_address = adcrs_pkg::NO_ADDR;
        result_next.busy_res    = busy;
        emit                    = in_fire;

        if (in_fire)
        begin
            case (op)
                adcrs_pkg::OP_START:
                begin
                    if ((num_reads == 8'd0) || busy)
                    begin
                        result_next.kind = adcrs_pkg::KIND_START_REJECT;
                    end
                    else
                    begin
                        // open a new batch; pin history carries over
                        batch_length_next   = num_reads;
                        requests_done_next  = 8'd0;
                        next_data_slot_next = '0;
                        samples_left_next   = 5'd0;
                        running_sum_next    = 16'd0;
                        summing_mode_next   = 1'b0;
                        phase_next          = adcrs_pkg::PH_REQ;
                        result_next.kind     = adcrs_pkg::KIND_START_ACCEPT;
                        result_next.busy_res = 1'b1;
                    end
                end
                adcrs_pkg::OP_REQUEST:
                begin
                    if (phase_reg != adcrs_pkg::PH_REQ)
                    begin
                        result_next.kind = adcrs_pkg::KIND_DROPPED;
                    end
                    else if (dec.bad)
                    begin
                        // count it as done, no data, leave mux pins alone
                        requests_done_next   = done_inc;
                        phase_next           = more ? adcrs_pkg::PH_REQ : adcrs_pkg::PH_IDLE;
                        result_next.kind     = adcrs_pkg::KIND_BAD_REQUEST;
                        result_next.busy_res = more;
                    end
                    else
                    begin
                        result_next.kind        = adcrs_pkg::KIND_SETUP;
                        result_next.release_pin = dec.release_pin;
                        result_next.assert_pin  = dec.assert_pin;
                        result_next.mux_address = dec.mux_address;
                        result_next.channel_mask     = dec.f.mask;
                        result_next.conversion_count = dec.f.sweep ? 4'd0 : dec.f.count;
                        result_next.sweep_mode       = dec.f.sweep;
                        result_next.busy_res         = 1'b1;
                        if (dec.f.mux_sel)
                        begin
                            previous_enable_next = {1'b0, dec.f.enable};
                        end
                        summing_mode_next = dec.sum_mode;
                        samples_left_next = {1'b0, dec.f.count} + 5'd1;
                        running_sum_next  = 16'd0;
                        phase_next        = adcrs_pkg::PH_SAMP;
                    end
                end
                adcrs_pkg::OP_SAMPLE:
                begin
                    if (phase_reg == adcrs_pkg::PH_SAMP)
                    begin
                        samples_left_next = left;
                        if (summing_mode_reg)
                        begin
                            running_sum_next = sum;
                        end
                        if (summing_mode_reg && !last)
                        begin
                            // accumulate silently until the last sample
                            emit = 1'b0;
                        end
                        else
                        begin
                            next_data_slot_next = next_data_slot_reg + SLOT_W'(1);
                            if (last)
                            begin
                                requests_done_next = done_inc;
                                phase_next = more ? adcrs_pkg::PH_REQ : adcrs_pkg::PH_IDLE;
                            end
                            result_next.kind       = adcrs_pkg::KIND_DATA;
                            result_next.data_value = summing_mode_reg ? sum : smp;
                            result_next.data_index = 6'(next_data_slot_reg);
                            result_next.batch_done = last && !more;
                            result_next.busy_res   = last ? more : busy;
                        end
                    end
                    else
                    begin
                        result_next.kind = adcrs_pkg::KIND_DROPPED;
                    end
                end
                default:
                begin
                    result_next.kind = adcrs_pkg::KIND_DROPPED;
                end
            endcase
        end

        // hold a result until taken, load a new one when produced
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_pin_count_reg  <= 5'd0;
            address_pin_count_reg <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                adcrs_pkg::CFG_ENABLE_PINS:  enable_pin_count_reg  <= cfg_data;
                adcrs_pkg::CFG_ADDRESS_PINS: address_pin_count_reg <= cfg_data[2:0];
                default:                     enable_pin_count_reg  <= enable_pin_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= adcrs_pkg::PH_IDLE;
            batch_length_reg    <= 8'd0;
            requests_done_reg   <= 8'd0;
            next_data_slot_reg  <= '0;
            samples_left_reg    <= 5'd0;
            running_sum_reg     <= 16'd0;
            summing_mode_reg    <= 1'b0;
            previous_enable_reg <= adcrs_pkg::NO_PIN;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            batch_length_reg    <= batch_length_next;
            requests_done_reg   <= requests_done_next;
            next_data_slot_reg  <= next_data_slot_next;
            samples_left_reg    <= samples_left_next;
            running_sum_reg     <= running_sum_next;
            summing_mode_reg    <= summing_mode_next;
            previous_enable_reg <= previous_enable_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // result payload: load only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid        = out_valid_reg;
    assign kind             = result_reg.kind;
    assign release_pin      = result_reg.release_pin;
    assign assert_pin       = result_reg.assert_pin;
    assign mux_address      = result_reg.mux_address;
    assign channel_mask     = result_reg.channel_mask;
    assign conversion_count = result_reg.conversion_count;
    assign sweep_mode       = result_reg.sweep_mode;
    assign data_value       = result_reg.data_value;
    assign data_index       = result_reg.data_index;
    assign batch_done       = result_reg.batch_done;
    assign busy_res         = result_reg.busy_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ADCRS_ASSERT_SAME(a_samp_busy, phase_reg == adcrs_pkg::PH_SAMP, (requests_done_reg < batch_length_reg) && (samples_left_reg != 5'd0), "sample phase without an open request")
    `ADCRS_ASSERT_SAME(a_slot_bound, 1'b1, next_data_slot_reg <= SLOT_W'(DATA_DEPTH), "data slot beyond store depth")
    `ADCRS_ASSERT_SAME(a_done_idle, out_valid && (kind == adcrs_pkg::KIND_DATA) && batch_done, !busy_res && (phase_reg == adcrs_pkg::PH_IDLE), "batch done while still busy")
    `ADCRS_ASSERT_NEXT(a_start_req, in_fire && (op == adcrs_pkg::OP_START) && (num_reads != 8'd0) && (requests_done_reg >= batch_length_reg), phase_reg == adcrs_pkg::PH_REQ, "accepted start did not open a batch")

endmodule
